// ----- hdl/charge_precharge_contactor_sequencer_defines.svh -----
// assertion helpers shared by the sequencer rtl
`ifndef CHARGE_PRECHARGE_CONTACTOR_SEQUENCER_DEFINES_SVH
`define CHARGE_PRECHARGE_CONTACTOR_SEQUENCER_DEFINES_SVH

// same-cycle implication, off while reset is high
`define CPCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define CPCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/cpcs_pkg.sv -----
package cpcs_pkg;

   // register indexes on the csr port
   localparam logic [2:0] REG_RAMP_START       = 3'd0;
   localparam logic [2:0] REG_RAMP_STEP        = 3'd1;
   localparam logic [2:0] REG_RAMP_CEILING     = 3'd2;
   localparam logic [2:0] REG_PRECHARGE_CLOSE  = 3'd3;
   localparam logic [2:0] REG_MAIN_CLOSE       = 3'd4;
   localparam logic [2:0] REG_PRECHARGE_OPEN   = 3'd5;
   localparam logic [2:0] REG_DISCONNECT       = 3'd6;
   localparam logic [2:0] REG_RECONNECT        = 3'd7;

   // register reset values
   localparam logic [11:0] RAMP_START_RST      = 12'd1200;
   localparam logic [7:0]  RAMP_STEP_RST       = 8'd4;
   localparam logic [11:0] RAMP_CEILING_RST    = 12'd4090;
   localparam logic [11:0] PRECHARGE_CLOSE_RST = 12'd100;
   localparam logic [11:0] MAIN_CLOSE_RST      = 12'd1000;
   localparam logic [11:0] PRECHARGE_OPEN_RST  = 12'd1200;
   localparam logic [13:0] DISCONNECT_RST      = 14'd6000;
   localparam logic [13:0] RECONNECT_RST       = 14'd6199;

   // frame identifiers
   localparam logic [10:0] ID_MODE     = 11'h100;
   localparam logic [10:0] ID_INFO_A   = 11'h101;
   localparam logic [10:0] ID_ERROR    = 11'h102;
   localparam logic [10:0] ID_SETPT_A  = 11'h200;
   localparam logic [10:0] ID_SETPT_B  = 11'h201;
   localparam logic [10:0] ID_SOC      = 11'h202;
   localparam logic [10:0] ID_SETPT_C  = 11'h203;

   // mode nibble codes and limits
   localparam logic [3:0]  MODE_PRECHARGE = 4'd5;
   localparam logic [3:0]  MODE_CHARGE    = 4'd6;
   localparam logic [3:0]  LEVEL_LIMIT    = 4'd3;
   localparam logic [11:0] CODE_MAX       = 12'hFFF;
   localparam logic [11:0] TICK_MAX       = 12'hFFF;

   // item kinds
   localparam logic CMD_FRAME = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // bms status codes
   localparam logic [1:0] STATUS_PRECHARGING = 2'd0;
   localparam logic [1:0] STATUS_CHARGING    = 2'd1;
   localparam logic [1:0] STATUS_FAULTED     = 2'd2;
   localparam logic [1:0] STATUS_IDLE        = 2'd3;

   typedef struct packed {
      logic [11:0] ramp_start;
      logic [7:0]  ramp_step;
      logic [11:0] ramp_ceiling;
      logic [11:0] precharge_close_tick;
      logic [11:0] main_close_tick;
      logic [11:0] precharge_open_tick;
      logic [13:0] disconnect_tick;
      logic [13:0] reconnect_tick;
   } cfg_type;

   // mode bit0 precharge, bit1 charge; fault bit0 low level, bit1 controller;
   // pins bit0 precharge, bit1 main, bit2 cp/pp disconnect
   typedef struct packed {
      logic [11:0] ramp_code;
      logic [11:0] charge_ticks;
      logic [13:0] abort_ticks;
      logic        was_charging;
      logic [1:0]  mode_flags;
      logic [1:0]  fault_flags;
      logic [7:0]  soc_raw;
      logic [2:0]  pin_states;
   } state_type;

   typedef struct packed {
      logic        dac_write;
      logic [11:0] dac_code;
      logic        precharge_contactor;
      logic        main_contactor;
      logic        cp_pp_disconnect;
      logic        frame_known;
      logic        precharging;
      logic        charging;
      logic        low_level_fault;
      logic        controller_fault;
      logic [13:0] soc_centi;
      logic [1:0]  bms_status;
   } result_type;

endpackage

// ----- hdl/cpcs_step.sv -----
module cpcs_step (
   input  cpcs_pkg::cfg_type    cfg,
   input  cpcs_pkg::state_type  st,
   input  logic                 cmd,
   input  logic [10:0]          frame_id,
   input  logic [7:0]           byte_zero,
   input  logic [7:0]           byte_one,
   input  logic [7:0]           byte_two,
   output cpcs_pkg::state_type  st_next,
   output cpcs_pkg::result_type res
);

   logic        pre;
   logic        chg;
   logic [11:0] raised;
   logic [12:0] ramp_sum;
   logic [11:0] stepped;
   logic        known;
   logic        dac_write;
   logic [13:0] soc_centi;

   assign pre = st.mode_flags[0];
   assign chg = st.mode_flags[1];

   // ramp candidate: lift to start, add step, saturate at full scale
   assign raised   = (st.ramp_code < cfg.ramp_start) ? cfg.ramp_start : st.ramp_code;
   assign ramp_sum = {1'b0, raised} + {5'b0, cfg.ramp_step};
   assign stepped  = ramp_sum[12] ? cpcs_pkg::CODE_MAX : ramp_sum[11:0];

   // next state for one item
   always_comb begin
      st_next   = st;
      known     = 1'b0;
      dac_write = 1'b0;
      if (cmd == cpcs_pkg::CMD_FRAME) begin
         known = 1'b1;
         case (frame_id)
            cpcs_pkg::ID_MODE: begin
               st_next.fault_flags[0] = (byte_two[7:4] >= cpcs_pkg::LEVEL_LIMIT);
               if (byte_one[3:0] == cpcs_pkg::MODE_PRECHARGE) begin
                  st_next.mode_flags = 2'b01;
               end else if (byte_one[3:0] == cpcs_pkg::MODE_CHARGE) begin
                  st_next.mode_flags = 2'b10;
               end else begin
                  st_next.mode_flags = 2'b00;
               end
            end
            cpcs_pkg::ID_ERROR: st_next.fault_flags[1] = (byte_one != 8'd0);
            cpcs_pkg::ID_SOC:   st_next.soc_raw = byte_zero;
            cpcs_pkg::ID_SETPT_A, cpcs_pkg::ID_SETPT_B,
            cpcs_pkg::ID_SETPT_C: known = 1'b1;
            default: known = 1'b0;
         endcase
      end else begin
         // precharge dac ramp
         if (pre) begin
            st_next.ramp_code = (raised <= cfg.ramp_ceiling) ? stepped : raised;
            dac_write = 1'b1;
         end else if (st.ramp_code != 12'd0) begin
            st_next.ramp_code = 12'd0;
            dac_write = 1'b1;
         end

         // contactor timing, first matching tick wins
         if (chg) begin
            if (st.charge_ticks == cfg.precharge_close_tick) begin
               st_next.pin_states[0] = 1'b1;
            end else if (st.charge_ticks == cfg.main_close_tick) begin
               st_next.pin_states[1] = 1'b1;
            end else if (st.charge_ticks == cfg.precharge_open_tick) begin
               st_next.pin_states[0] = 1'b0;
            end
            if (st.charge_ticks <= cfg.precharge_open_tick &&
                st.charge_ticks != cpcs_pkg::TICK_MAX) begin
               st_next.charge_ticks = st.charge_ticks + 12'd1;
            end
         end else if (st.charge_ticks != 12'd0) begin
            st_next.pin_states[1:0] = 2'b00;
            st_next.charge_ticks    = 12'd0;
         end

         // cp/pp recovery after a charge abort
         if (chg) begin
            st_next.was_charging = 1'b1;
            st_next.abort_ticks  = 14'd0;
         end else if (st.was_charging) begin
            if (st.abort_ticks == cfg.disconnect_tick) begin
               st_next.pin_states[2] = 1'b1;
               st_next.abort_ticks   = st.abort_ticks + 14'd1;
            end else if (st.abort_ticks >= cfg.reconnect_tick) begin
               st_next.pin_states[2] = 1'b0;
               st_next.was_charging  = 1'b0;
               st_next.abort_ticks   = 14'd0;
            end else begin
               st_next.abort_ticks = st.abort_ticks + 14'd1;
            end
         end
      end
   end

   // soc times 50 as shifts and adds
   assign soc_centi = {1'b0, st_next.soc_raw, 5'b0} + {2'b0, st_next.soc_raw, 4'b0}
                    + {5'b0, st_next.soc_raw, 1'b0};

   // result item from the updated state
   always_comb begin
      res.dac_write           = dac_write;
      res.dac_code            = st_next.ramp_code;
      res.precharge_contactor = st_next.pin_states[0];
      res.main_contactor      = st_next.pin_states[1];
      res.cp_pp_disconnect    = st_next.pin_states[2];
      res.frame_known         = known;
      res.precharging         = st_next.mode_flags[0];
      res.charging            = st_next.mode_flags[1];
      res.low_level_fault     = st_next.fault_flags[0];
      res.controller_fault    = st_next.fault_flags[1];
      res.soc_centi           = soc_centi;
      if (st_next.mode_flags[0]) begin
         res.bms_status = cpcs_pkg::STATUS_PRECHARGING;
      end else if (st_next.mode_flags[1]) begin
         res.bms_status = cpcs_pkg::STATUS_CHARGING;
      end else if (st_next.fault_flags != 2'b00) begin
         res.bms_status = cpcs_pkg::STATUS_FAULTED;
      end else begin
         res.bms_status = cpcs_pkg::STATUS_IDLE;
      end
   end

endmodule

// ----- hdl/charge_precharge_contactor_sequencer.sv -----
// output: a result item is registered and appears in the cycle after its input item is accepted
// throughput: one item per cycle; the only stall is a full result register
//   whose item is not taken in the same cycle
// reset: synchronous, active high; registers return to their defaults, all
//   contactors open, cp/pp connected, ramp, counters, flags and soc cleared
`include "charge_precharge_contactor_sequencer_defines.svh"

module charge_precharge_contactor_sequencer (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // frame_id[10:0], byte_zero[18:11], byte_one[26:19],
                                    // byte_two[34:27], zero[39:35]
   input  logic        req_tuser,   // cmd[0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // dac_write[0], dac_code[12:1],
                                    // precharge_contactor[13], main_contactor[14],
                                    // cp_pp_disconnect[15], frame_known[16],
                                    // precharging[17], charging[18],
                                    // low_level_fault[19], controller_fault[20],
                                    // soc_centi[34:21], bms_status[36:35], zero[39:37]
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cpcs_pkg::cfg_type    cfg_ff, cfg_in;
   cpcs_pkg::state_type  state_ff, state_in;
   cpcs_pkg::result_type res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 req_accept;
   logic                 csr_write;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_paddr[4:2])
            cpcs_pkg::REG_RAMP_START:      cfg_in.ramp_start           = csr_pwdata[11:0];
            cpcs_pkg::REG_RAMP_STEP:       cfg_in.ramp_step            = csr_pwdata[7:0];
            cpcs_pkg::REG_RAMP_CEILING:    cfg_in.ramp_ceiling         = csr_pwdata[11:0];
            cpcs_pkg::REG_PRECHARGE_CLOSE: cfg_in.precharge_close_tick = csr_pwdata[11:0];
            cpcs_pkg::REG_MAIN_CLOSE:      cfg_in.main_close_tick      = csr_pwdata[11:0];
            cpcs_pkg::REG_PRECHARGE_OPEN:  cfg_in.precharge_open_tick  = csr_pwdata[11:0];
            cpcs_pkg::REG_DISCONNECT:      cfg_in.disconnect_tick      = csr_pwdata[13:0];
            cpcs_pkg::REG_RECONNECT:       cfg_in.reconnect_tick       = csr_pwdata[13:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   // register read back
   always_comb begin
      case (csr_paddr[4:2])
         cpcs_pkg::REG_RAMP_START:      csr_prdata = {20'd0, cfg_ff.ramp_start};
         cpcs_pkg::REG_RAMP_STEP:       csr_prdata = {24'd0, cfg_ff.ramp_step};
         cpcs_pkg::REG_RAMP_CEILING:    csr_prdata = {20'd0, cfg_ff.ramp_ceiling};
         cpcs_pkg::REG_PRECHARGE_CLOSE: csr_prdata = {20'd0, cfg_ff.precharge_close_tick};
         cpcs_pkg::REG_MAIN_CLOSE:      csr_prdata = {20'd0, cfg_ff.main_close_tick};
         cpcs_pkg::REG_PRECHARGE_OPEN:  csr_prdata = {20'd0, cfg_ff.precharge_open_tick};
         cpcs_pkg::REG_DISCONNECT:      csr_prdata = {18'd0, cfg_ff.disconnect_tick};
         cpcs_pkg::REG_RECONNECT:       csr_prdata = {18'd0, cfg_ff.reconnect_tick};
         default:                       csr_prdata = 32'd0;
      endcase
   end

   // item handshake: take a new item whenever the result register frees up
   assign req_tready   = ~rsp_valid_ff | rsp_tready;
   assign req_accept   = req_tvalid & req_tready;
   assign rsp_valid_in = req_accept | (rsp_valid_ff & ~rsp_tready);

   // per-item update logic
   cpcs_step u_step (
      .cfg       (cfg_ff),
      .st        (state_ff),
      .cmd       (req_tuser),
      .frame_id  (req_tdata[10:0]),
      .byte_zero (req_tdata[18:11]),
      .byte_one  (req_tdata[26:19]),
      .byte_two  (req_tdata[34:27]),
      .st_next   (state_in),
      .res       (res_in)
   );

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_start           <= cpcs_pkg::RAMP_START_RST;
         cfg_ff.ramp_step            <= cpcs_pkg::RAMP_STEP_RST;
         cfg_ff.ramp_ceiling         <= cpcs_pkg::RAMP_CEILING_RST;
         cfg_ff.precharge_close_tick <= cpcs_pkg::PRECHARGE_CLOSE_RST;
         cfg_ff.main_close_tick      <= cpcs_pkg::MAIN_CLOSE_RST;
         cfg_ff.precharge_open_tick  <= cpcs_pkg::PRECHARGE_OPEN_RST;
         cfg_ff.disconnect_tick      <= cpcs_pkg::DISCONNECT_RST;
         cfg_ff.reconnect_tick       <= cpcs_pkg::RECONNECT_RST;
         state_ff                    <= '0;
         rsp_valid_ff                <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            state_ff <= state_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, res_ff.bms_status, res_ff.soc_centi,
                        res_ff.controller_fault, res_ff.low_level_fault,
                        res_ff.charging, res_ff.precharging, res_ff.frame_known,
                        res_ff.cp_pp_disconnect, res_ff.main_contactor,
                        res_ff.precharge_contactor, res_ff.dac_code, res_ff.dac_write};

   // checks
   `CPCS_ASSERT_NOW(a_abort_idle, clock, reset, !state_ff.was_charging,
      state_ff.abort_ticks == 14'd0, "abort counter running outside recovery")
   `CPCS_ASSERT_NEXT(a_ramp_cleared, clock, reset,
      req_accept && req_tuser == cpcs_pkg::CMD_TICK && !state_ff.mode_flags[0],
      state_ff.ramp_code == 12'd0, "ramp code left set after a tick without precharge")
   `CPCS_ASSERT_NEXT(a_contactors_open, clock, reset,
      req_accept && req_tuser == cpcs_pkg::CMD_TICK && !state_ff.mode_flags[1],
      state_ff.charge_ticks == 12'd0 && state_ff.pin_states[1:0] == 2'b00,
      "contactors or charge counter left set after a tick without charge")
   `CPCS_ASSERT_NOW(a_stall_blocks, clock, reset, rsp_valid_ff && !rsp_tready,
      !req_tready, "input taken while the result register is held")

endmodule

// ----- bench/charge_precharge_contactor_sequencer_checker.sv -----
module charge_precharge_contactor_sequencer_checker
   import cpcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // frame_id[10:0], byte_zero[18:11], byte_one[26:19],
                                    // byte_two[34:27], zero[39:35]
   input  logic        req_tuser,   // cmd[0]
   // result channel
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // dac_write[0], dac_code[12:1],
                                    // precharge_contactor[13], main_contactor[14],
                                    // cp_pp_disconnect[15], frame_known[16],
                                    // precharging[17], charging[18],
                                    // low_level_fault[19], controller_fault[20],
                                    // soc_centi[34:21], bms_status[36:35], zero[39:37]
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   // to the top
   output int          mismatches,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow of the registers and of the sequencer state
   cfg_type     settings;
   logic [11:0] ramp_code;
   logic [11:0] charge_count;
   logic [13:0] abort_count;
   logic        was_charging;
   logic        precharging;
   logic        charging;
   logic        level_fault;
   logic        ctrl_fault;
   logic [7:0]  soc_byte;
   logic        pin_precharge;
   logic        pin_main;
   logic        pin_cp_pp;

   result_type  expected_status[$];
   result_type  want;
   int          result_index;

   // only the first hundred are printed, all are counted
   task automatic report_mismatch(string msg);
      if (mismatches < 100)
         $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_field(string name, int unsigned got, int unsigned exp_value);
      if (got != exp_value)
         report_mismatch($sformatf("result item %0d %s: got %0d, expected %0d",
                                   result_index, name, got, exp_value));
   endtask

   task automatic compare_result(logic [39:0] d, result_type e);
      check_field("dac_write",           d[0],      e.dac_write);
      check_field("dac_code",            d[12:1],   e.dac_code);
      check_field("precharge_contactor", d[13],     e.precharge_contactor);
      check_field("main_contactor",      d[14],     e.main_contactor);
      check_field("cp_pp_disconnect",    d[15],     e.cp_pp_disconnect);
      check_field("frame_known",         d[16],     e.frame_known);
      check_field("precharging",         d[17],     e.precharging);
      check_field("charging",            d[18],     e.charging);
      check_field("low_level_fault",     d[19],     e.low_level_fault);
      check_field("controller_fault",    d[20],     e.controller_fault);
      check_field("soc_centi",           d[34:21],  e.soc_centi);
      check_field("bms_status",          d[36:35],  e.bms_status);
   endtask

   // one frame or tick through the sequencer, returns the status it reports
   function automatic result_type advance_sequencer(logic cmd, logic [10:0] id,
                                                    logic [7:0] b0, logic [7:0] b1,
                                                    logic [7:0] b2);
      result_type r;
      logic       pre;
      logic       chg;
      logic [12:0] sum;
      r = '0;
      if (cmd == CMD_FRAME) begin
         r.frame_known = 1'b1;
         case (id)
            ID_MODE: begin
               level_fault = (b2[7:4] >= LEVEL_LIMIT);
               precharging = (b1[3:0] == MODE_PRECHARGE);
               charging    = (b1[3:0] == MODE_CHARGE);
            end
            ID_ERROR:   ctrl_fault = (b1 != 8'd0);
            ID_SOC:     soc_byte = b0;
            ID_SETPT_A, ID_SETPT_B, ID_SETPT_C: ;
            default:    r.frame_known = 1'b0;
         endcase
      end else begin
         pre = precharging;
         chg = charging;

         // dac ramp, held at zero outside precharge
         if (pre) begin
            if (ramp_code < settings.ramp_start)
               ramp_code = settings.ramp_start;
            if (ramp_code <= settings.ramp_ceiling) begin
               sum = {1'b0, ramp_code} + 13'(settings.ramp_step);
               ramp_code = sum[12] ? CODE_MAX : sum[11:0];
            end
            r.dac_write = 1'b1;
         end else if (ramp_code != 12'd0) begin
            ramp_code = 12'd0;
            r.dac_write = 1'b1;
         end

         // contactor timing, first matching tick wins
         if (chg) begin
            if (charge_count == settings.precharge_close_tick)
               pin_precharge = 1'b1;
            else if (charge_count == settings.main_close_tick)
               pin_main = 1'b1;
            else if (charge_count == settings.precharge_open_tick)
               pin_precharge = 1'b0;
            if (charge_count <= settings.precharge_open_tick && charge_count < TICK_MAX)
               charge_count = charge_count + 12'd1;
         end else if (charge_count != 12'd0) begin
            pin_precharge = 1'b0;
            pin_main      = 1'b0;
            charge_count  = 12'd0;
         end

         // cp/pp disconnect and reconnect after an abort
         if (chg) begin
            was_charging = 1'b1;
            abort_count  = 14'd0;
         end else if (was_charging) begin
            if (abort_count == settings.disconnect_tick) begin
               pin_cp_pp   = 1'b1;
               abort_count = abort_count + 14'd1;
            end else if (abort_count >= settings.reconnect_tick) begin
               pin_cp_pp    = 1'b0;
               was_charging = 1'b0;
               abort_count  = 14'd0;
            end else begin
               abort_count = abort_count + 14'd1;
            end
         end
      end

      r.dac_code            = ramp_code;
      r.precharge_contactor = pin_precharge;
      r.main_contactor      = pin_main;
      r.cp_pp_disconnect    = pin_cp_pp;
      r.precharging         = precharging;
      r.charging            = charging;
      r.low_level_fault     = level_fault;
      r.controller_fault    = ctrl_fault;
      r.soc_centi           = 14'(soc_byte * 14'd50);
      if (precharging)
         r.bms_status = STATUS_PRECHARGING;
      else if (charging)
         r.bms_status = STATUS_CHARGING;
      else if (level_fault || ctrl_fault)
         r.bms_status = STATUS_FAULTED;
      else
         r.bms_status = STATUS_IDLE;
      return r;
   endfunction

   // watch register writes, items and results
   always @(posedge clock) begin
      if (reset) begin
         settings = '{RAMP_START_RST, RAMP_STEP_RST, RAMP_CEILING_RST, PRECHARGE_CLOSE_RST,
                      MAIN_CLOSE_RST, PRECHARGE_OPEN_RST, DISCONNECT_RST, RECONNECT_RST};
         ramp_code     = '0;
         charge_count  = '0;
         abort_count   = '0;
         was_charging  = 1'b0;
         precharging   = 1'b0;
         charging      = 1'b0;
         level_fault   = 1'b0;
         ctrl_fault    = 1'b0;
         soc_byte      = '0;
         pin_precharge = 1'b0;
         pin_main      = 1'b0;
         pin_cp_pp     = 1'b0;
         result_index  = 0;
         expected_status.delete();
         outstanding   = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_RAMP_START:      settings.ramp_start           = csr_pwdata[11:0];
               REG_RAMP_STEP:       settings.ramp_step            = csr_pwdata[7:0];
               REG_RAMP_CEILING:    settings.ramp_ceiling         = csr_pwdata[11:0];
               REG_PRECHARGE_CLOSE: settings.precharge_close_tick = csr_pwdata[11:0];
               REG_MAIN_CLOSE:      settings.main_close_tick      = csr_pwdata[11:0];
               REG_PRECHARGE_OPEN:  settings.precharge_open_tick  = csr_pwdata[11:0];
               REG_DISCONNECT:      settings.disconnect_tick      = csr_pwdata[13:0];
               REG_RECONNECT:       settings.reconnect_tick       = csr_pwdata[13:0];
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            if (expected_status.size() == 0) begin
               report_mismatch($sformatf("result item 0x%h with none expected", rsp_tdata));
            end else begin
               want = expected_status.pop_front();
               compare_result(rsp_tdata, want);
            end
            result_index++;
         end

         if (req_tvalid && req_tready)
            expected_status.push_back(advance_sequencer(req_tuser, req_tdata[10:0],
                                                        req_tdata[18:11], req_tdata[26:19],
                                                        req_tdata[34:27]));
         outstanding = expected_status.size();
      end
   end

endmodule

// ----- bench/charge_precharge_contactor_sequencer_tb.sv -----
module charge_precharge_contactor_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cpcs_pkg::*;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;     // frame_id[10:0], byte_zero[18:11], byte_one[26:19],
                                    // byte_two[34:27], zero[39:35]
   logic        req_tuser = CMD_FRAME; // cmd[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;          // dac_write[0], dac_code[12:1], precharge_contactor[13],
                                    // main_contactor[14], cp_pp_disconnect[15],
                                    // frame_known[16], precharging[17], charging[18],
                                    // low_level_fault[19], controller_fault[20],
                                    // soc_centi[34:21], bms_status[36:35], zero[39:37]
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          mismatches;
   int          outstanding;
   int          idle_pct = 12;
   int          items_sent = 0;

   charge_precharge_contactor_sequencer u_dut (.*);

   charge_precharge_contactor_sequencer_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result side back-pressure
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= idle_pct);

   // hard stop
   initial begin
      #5_000_000;
      $display("charge_precharge_contactor_sequencer_tb failed");
      $finish;
   end

   task automatic send_item(logic cmd, logic [10:0] id, logic [7:0] b0, logic [7:0] b1,
                            logic [7:0] b2);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {5'd0, b2, b1, b0, id};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_frame(logic [10:0] id, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
      send_item(CMD_FRAME, id, b0, b1, b2);
   endtask

   // payload of a tick is don't-care, so it is random
   task automatic send_tick();
      send_item(CMD_TICK, 11'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // stray frame; with keep_mode set the mode frame is left out
   task automatic send_noise(logic keep_mode);
      logic [10:0] id;
      logic [7:0]  b1;
      case ($urandom_range(9))
         0, 1:    id = ID_SOC;
         2, 3:    id = ID_ERROR;
         4:       id = ID_SETPT_A;
         5:       id = ID_SETPT_B;
         6:       id = ID_SETPT_C;
         7:       id = ID_INFO_A;
         8:       id = ID_MODE;
         default: id = 11'($urandom);
      endcase
      if (keep_mode && id == ID_MODE)
         id = ID_SOC;
      b1 = 8'($urandom);
      if (id == ID_ERROR && $urandom_range(1) == 0)
         b1 = 8'd0;
      send_frame(id, 8'($urandom), b1, 8'($urandom));
   endtask

   task automatic run_ticks(int n, logic keep_mode, int noise_pct);
      repeat (n) begin
         if ($urandom_range(99) < noise_pct)
            send_noise(keep_mode);
         else
            send_tick();
      end
   endtask

   // precharge, charge, abort and recovery with random timing and stray frames
   task automatic run_session(int span, int noise_pct);
      logic [3:0] nib;
      send_frame(ID_MODE, 8'($urandom), {4'($urandom), MODE_PRECHARGE}, 8'($urandom));
      run_ticks($urandom_range(1, span), 1'b1, noise_pct);
      if ($urandom_range(9) != 0)
         send_frame(ID_MODE, 8'($urandom), {4'($urandom), MODE_CHARGE}, 8'($urandom));
      run_ticks($urandom_range(1, 2 * span), 1'b1, noise_pct);
      do nib = 4'($urandom); while (nib == MODE_CHARGE);
      send_frame(ID_MODE, 8'($urandom), {4'($urandom), nib}, 8'($urandom));
      run_ticks($urandom_range(1, 3 * span), 1'b0, noise_pct);
   endtask

   task automatic csr_write(logic [2:0] index, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic write_settings(cfg_type c);
      csr_write(REG_RAMP_START,      32'(c.ramp_start));
      csr_write(REG_RAMP_STEP,       32'(c.ramp_step));
      csr_write(REG_RAMP_CEILING,    32'(c.ramp_ceiling));
      csr_write(REG_PRECHARGE_CLOSE, 32'(c.precharge_close_tick));
      csr_write(REG_MAIN_CLOSE,      32'(c.main_close_tick));
      csr_write(REG_PRECHARGE_OPEN,  32'(c.precharge_open_tick));
      csr_write(REG_DISCONNECT,      32'(c.disconnect_tick));
      csr_write(REG_RECONNECT,       32'(c.reconnect_tick));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // every item gives one result, so an empty scoreboard means idle
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   function automatic int unsigned pick_value(int unsigned reach, int unsigned top);
      case ($urandom_range(11))
         0:       return 0;
         1:       return top;
         default: return $urandom_range(reach);
      endcase
   endfunction

   function automatic cfg_type pick_settings(int unsigned reach);
      cfg_type c;
      c.ramp_start           = 12'(pick_value(4095, 4095));
      c.ramp_step            = 8'(pick_value(255, 255));
      c.ramp_ceiling         = 12'(pick_value(4095, 4095));
      c.precharge_close_tick = 12'(pick_value(reach, 4095));
      c.main_close_tick      = 12'(pick_value(reach, 4095));
      c.precharge_open_tick  = 12'(pick_value(2 * reach, 4095));
      c.disconnect_tick      = 14'(pick_value(2 * reach, 16383));
      c.reconnect_tick       = 14'(pick_value(2 * reach, 16383));
      return c;
   endfunction

   initial begin
      cfg_type     c;
      int          random_start;
      int          phase;
      int          reach;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: unknown id, precharge with level fault at its limit, one ramp step
      send_frame(11'h7FF, 8'hFF, 8'hFF, 8'hFF);
      send_frame(ID_MODE, 8'h00, {4'h0, MODE_PRECHARGE}, 8'h30);
      send_tick();

      // short timings, ramp start above the code, saturating step, coinciding closes,
      // disconnect on the reconnect tick
      wait_drain();
      c = '{12'd4000, 8'd255, CODE_MAX, 12'd1, 12'd1, 12'd3, 14'd2, 14'd2};
      write_settings(c);
      send_tick();
      send_tick();
      send_frame(ID_SOC, 8'hFF, 8'h00, 8'h00);
      send_frame(ID_ERROR, 8'h00, 8'h80, 8'h00);
      send_frame(ID_INFO_A, 8'h12, 8'h34, 8'h56);
      send_frame(ID_MODE, 8'h00, {4'hF, MODE_CHARGE}, 8'h20);
      repeat (5) send_tick();
      send_frame(ID_SETPT_A, 8'hAA, 8'h55, 8'hFF);
      send_frame(ID_SETPT_B, 8'h55, 8'hAA, 8'h00);
      send_frame(ID_SETPT_C, 8'hFF, 8'hFF, 8'hFF);
      send_frame(ID_MODE, 8'h00, 8'h00, 8'h00);
      repeat (4) send_tick();
      send_frame(11'h000, 8'h00, 8'h00, 8'h00);

      // random sessions under changing settings
      random_start = items_sent;
      phase = 0;
      while (items_sent - random_start < 1750) begin
         wait_drain();
         reach = $urandom_range(4, 40);
         c = pick_settings(reach);
         case (phase)
            1: c = '{12'd0, 8'd0, 12'd0, 12'd0, 12'd0, 12'd0, 14'd0, 14'd0};
            2: c = '{CODE_MAX, 8'd255, CODE_MAX, TICK_MAX, TICK_MAX, TICK_MAX,
                     14'h3FFF, 14'h3FFF};
            3: c = '{RAMP_START_RST, RAMP_STEP_RST, RAMP_CEILING_RST, PRECHARGE_CLOSE_RST,
                     MAIN_CLOSE_RST, PRECHARGE_OPEN_RST, DISCONNECT_RST, RECONNECT_RST};
            default: ;
         endcase
         write_settings(c);
         idle_pct = (phase % 5 == 4) ? 0 : 12;
         repeat (3) run_session(reach + 10, 15);
         phase++;
      end

      wait_drain();
      idle_pct = 0;
      repeat (4) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("charge_precharge_contactor_sequencer_tb passed");
      else
         $display("charge_precharge_contactor_sequencer_tb failed");
      $finish;
   end

endmodule
